// File: rtl/core/dpss_pkg.sv
// shared constants and controller/datapath types for the dual playhead step sequencer
// no dependencies
`timescale 1ns / 1ps

package dpss_pkg;

  localparam int MAX_STEPS   = 16;
  localparam int SHORT_STEPS = 8;

  localparam int COL_W  = 4;
  localparam int ROW_W  = 3;
  localparam int AMT_W  = 8;
  localparam int CNT_W  = 7;
  localparam int POS_W  = 4;
  localparam int PAT_W  = 4;
  localparam int SIZE_W = $clog2(MAX_STEPS) + 1;
  localparam int HEADS  = 2;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_LONG_PATTERN = 1'b0;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_KEY  = 1'b1;

  typedef struct packed {
    logic load_tick;
    logic step;
    logic key_loop;
    logic rd_key;
    logic tgl_write;
    logic rd_heads;
    logic emit;
  } dpss_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic out_busy;
  } dpss_sts_t;

endpackage

// File: rtl/core/dpss_chan_if.sv
// valid/ready channel interfaces for the input word and the result word
// depends on dpss_pkg
`timescale 1ns / 1ps

interface dpss_in_if
  import dpss_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic signed [AMT_W-1:0] step_amount;
  logic [COL_W-1:0]        key_column;
  logic [ROW_W-1:0]        key_row;
  logic                    key_down;

  modport source (output valid, mode, step_amount, key_column, key_row, key_down,
                  input ready);
  modport sink (input valid, mode, step_amount, key_column, key_row, key_down,
                output ready);
endinterface

interface dpss_out_if
  import dpss_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PAT_W-1:0] pattern_first;
  logic [POS_W-1:0] position_first;
  logic [PAT_W-1:0] pattern_second;
  logic [POS_W-1:0] position_second;

  modport source (output valid, pattern_first, position_first, pattern_second,
                  position_second, input ready);
  modport sink (input valid, pattern_first, position_first, pattern_second,
                position_second, output ready);
endinterface

// File: rtl/core/dual_playhead_step_sequencer_top.sv
// Dual playhead step sequencer. One word is taken at a time. A tick word moves both
// playheads by its amount, saturated to +-127, one unit per clock cycle, but a playhead
// whose loop start was set since the last result holds still. One result is given, and
// the next word is taken once it is in the output register, even while it waits there.
// A loop-point key press sets a loop point; a pattern key press reads then writes the
// pattern memory. The per-unit playhead stepper sets the tick latency. Key events give
// no result. long_pattern at byte address 0 selects 16 active steps instead of 8.
// top level: depends on dpss_pkg, dpss_chan_if, dpss_cfg, dpss_ctrl, dpss_dp
`timescale 1ns / 1ps

module dual_playhead_step_sequencer_top
  import dpss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  dpss_in_if.sink               in_word,
  dpss_out_if.source            out_word,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic      long_pattern;
  dpss_cmd_t cmd;
  dpss_sts_t sts;

  dpss_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (cfg_psel),
    .penable      (cfg_penable),
    .pwrite       (cfg_pwrite),
    .paddr        (cfg_paddr),
    .pwdata       (cfg_pwdata),
    .prdata       (cfg_prdata),
    .pready       (cfg_pready),
    .long_pattern (long_pattern)
  );

  dpss_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_word.valid),
    .in_mode        (in_word.mode),
    .in_key_down    (in_word.key_down),
    .in_key_pattern (in_word.key_row[ROW_W-1]),
    .in_ready       (in_word.ready),
    .sts            (sts),
    .cmd            (cmd)
  );

  dpss_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .long_pattern        (long_pattern),
    .in_step_amount      (in_word.step_amount),
    .in_key_column       (in_word.key_column),
    .in_key_row          (in_word.key_row),
    .out_valid           (out_word.valid),
    .out_ready           (out_word.ready),
    .out_pattern_first   (out_word.pattern_first),
    .out_position_first  (out_word.position_first),
    .out_pattern_second  (out_word.pattern_second),
    .out_position_second (out_word.position_second)
  );

endmodule

// File: rtl/core/dpss_cfg.sv
// apb-style configuration register block holding the pattern length select
// depends on dpss_pkg
`timescale 1ns / 1ps

module dpss_cfg
  import dpss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic                  long_pattern
);

  logic long_pattern_r;
  logic long_pattern_nxt;
  logic hit;

  assign hit = (paddr[2] == REG_LONG_PATTERN);

  always_comb begin
    long_pattern_nxt = long_pattern_r;
    if (psel && penable && pwrite && hit) begin
      long_pattern_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_pattern_r <= 1'b0;
    end else begin
      long_pattern_r <= long_pattern_nxt;
    end
  end

  assign prdata       = hit ? {{(CFG_DATA_W-1){1'b0}}, long_pattern_r} : '0;
  assign pready       = 1'b1;
  assign long_pattern = long_pattern_r;

endmodule

// File: rtl/core/dpss_ctrl.sv
// sequencer state machine: accepts words, runs unit steps, reads the pattern, emits results
// depends on dpss_pkg
`timescale 1ns / 1ps

module dpss_ctrl
  import dpss_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_mode,
  input  logic      in_key_down,
  input  logic      in_key_pattern,
  output logic      in_ready,
  input  dpss_sts_t sts,
  output dpss_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MOVE = 3'd1;
  localparam logic [2:0] ST_READ = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;
  localparam logic [2:0] ST_TGL  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_TICK) begin
            cmd.load_tick = 1'b1;
            state_nxt     = ST_MOVE;
          end else if (in_key_down) begin
            if (in_key_pattern) begin
              cmd.rd_key = 1'b1;
              state_nxt  = ST_TGL;
            end else begin
              cmd.key_loop = 1'b1;
            end
          end
        end
      end
      ST_MOVE: begin
        if (sts.cnt_zero) begin
          state_nxt = ST_READ;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_READ: begin
        cmd.rd_heads = 1'b1;
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_TGL: begin
        cmd.tgl_write = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/core/dpss_dp.sv
// datapath: playhead and loop registers, unit step logic, pattern memory, result register
// depends on dpss_pkg
`timescale 1ns / 1ps

module dpss_dp
  import dpss_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  dpss_cmd_t               cmd,
  output dpss_sts_t               sts,
  input  logic                    long_pattern,
  input  logic signed [AMT_W-1:0] in_step_amount,
  input  logic [COL_W-1:0]        in_key_column,
  input  logic [ROW_W-1:0]        in_key_row,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [PAT_W-1:0]        out_pattern_first,
  output logic [POS_W-1:0]        out_position_first,
  output logic [PAT_W-1:0]        out_pattern_second,
  output logic [POS_W-1:0]        out_position_second
);

  localparam int DEPTH = 1 << COL_W;

  logic [POS_W-1:0] pos_r   [HEADS];
  logic [POS_W-1:0] start_r [HEADS];
  logic [POS_W-1:0] end_r   [HEADS];
  logic [POS_W-1:0] len_r   [HEADS];
  logic [HEADS-1:0] cut_r;
  logic [CNT_W-1:0] cnt_r;
  logic             dir_r;
  logic             out_valid_r;

  logic [COL_W-1:0] key_col_r;
  logic [1:0]       key_bit_r;

  logic [PAT_W-1:0] pat_mem [DEPTH];
  logic [DEPTH-1:0] pat_vld_r;
  logic [PAT_W-1:0] rd_a_r;
  logic [PAT_W-1:0] rd_b_r;
  logic             vld_a_r;
  logic             vld_b_r;
  logic [COL_W-1:0] rd_a_addr;
  logic [PAT_W-1:0] data_a;
  logic [PAT_W-1:0] data_b;
  logic [PAT_W-1:0] tgl_data;

  logic [PAT_W-1:0] out_pat0_r;
  logic [POS_W-1:0] out_pos0_r;
  logic [PAT_W-1:0] out_pat1_r;
  logic [POS_W-1:0] out_pos1_r;

  logic [SIZE_W-1:0] size;
  logic [SIZE_W-1:0] size_m1;
  logic [CNT_W-1:0]  mag;
  logic [POS_W-1:0]  step_nxt [HEADS];

  logic              kh;
  logic [SIZE_W-1:0] new_end;
  logic [SIZE_W-1:0] new_len;

  assign size    = long_pattern ? SIZE_W'(MAX_STEPS) : SIZE_W'(SHORT_STEPS);
  assign size_m1 = size - SIZE_W'(1);

  // saturate to +-127 and take the magnitude
  always_comb begin
    if (in_step_amount == {1'b1, {(AMT_W-1){1'b0}}}) begin
      mag = {CNT_W{1'b1}};
    end else if (in_step_amount[AMT_W-1]) begin
      mag = CNT_W'(-in_step_amount);
    end else begin
      mag = in_step_amount[CNT_W-1:0];
    end
  end

  // one unit of movement per head
  always_comb begin
    logic [SIZE_W-1:0] fwd;
    for (int h = 0; h < HEADS; h++) begin
      fwd = {1'b0, pos_r[h]} + SIZE_W'(1);
      if (!dir_r) begin
        if (pos_r[h] == end_r[h]) begin
          step_nxt[h] = start_r[h];
        end else if (fwd == size) begin
          step_nxt[h] = '0;
        end else begin
          step_nxt[h] = fwd[POS_W-1:0];
        end
      end else begin
        if (pos_r[h] == start_r[h]) begin
          step_nxt[h] = end_r[h];
        end else if (pos_r[h] == '0) begin
          step_nxt[h] = size_m1[POS_W-1:0];
        end else begin
          step_nxt[h] = pos_r[h] - POS_W'(1);
        end
      end
    end
  end

  // loop point edits
  assign kh = in_key_row[1];

  always_comb begin
    new_end = {1'b0, in_key_column} + {1'b0, len_r[kh]};
    if (new_end > size_m1) begin
      new_end = new_end - size;
    end
    new_len = {1'b0, in_key_column} - {1'b0, start_r[kh]};
    if (new_len[SIZE_W-1]) begin
      new_len = new_len + size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int h = 0; h < HEADS; h++) begin
        pos_r[h]   <= '0;
        start_r[h] <= '0;
        end_r[h]   <= POS_W'(7);
        len_r[h]   <= POS_W'(7);
      end
      cut_r       <= '0;
      cnt_r       <= '0;
      dir_r       <= 1'b0;
      out_valid_r <= 1'b0;
      pat_vld_r   <= '0;
    end else begin
      if (cmd.load_tick) begin
        dir_r <= in_step_amount[AMT_W-1];
        cnt_r <= mag;
      end
      if (cmd.step) begin
        cnt_r <= cnt_r - CNT_W'(1);
        for (int h = 0; h < HEADS; h++) begin
          if (!cut_r[h]) begin
            pos_r[h] <= step_nxt[h];
          end
        end
      end
      if (cmd.key_loop) begin
        if (in_key_row[0]) begin
          end_r[kh] <= in_key_column;
          len_r[kh] <= new_len[POS_W-1:0];
        end else begin
          start_r[kh] <= in_key_column;
          pos_r[kh]   <= in_key_column;
          end_r[kh]   <= new_end[POS_W-1:0];
          cut_r[kh]   <= 1'b1;
        end
      end
      if (cmd.tgl_write) begin
        pat_vld_r[key_col_r] <= 1'b1;
      end
      if (cmd.emit) begin
        cut_r       <= '0;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // pattern memory, two registered read ports
  assign rd_a_addr = cmd.rd_key ? in_key_column : pos_r[0];

  always_ff @(posedge clk) begin
    if (cmd.tgl_write) begin
      pat_mem[key_col_r] <= tgl_data;
    end
    if (cmd.rd_key || cmd.rd_heads) begin
      rd_a_r  <= pat_mem[rd_a_addr];
      vld_a_r <= pat_vld_r[rd_a_addr];
    end
    if (cmd.rd_heads) begin
      rd_b_r  <= pat_mem[pos_r[1]];
      vld_b_r <= pat_vld_r[pos_r[1]];
    end
    if (cmd.rd_key) begin
      key_col_r <= in_key_column;
      key_bit_r <= in_key_row[1:0];
    end
  end

  assign data_a   = vld_a_r ? rd_a_r : '0;
  assign data_b   = vld_b_r ? rd_b_r : '0;
  assign tgl_data = data_a ^ (PAT_W'(1) << key_bit_r);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_pat0_r <= data_a;
      out_pos0_r <= pos_r[0];
      out_pat1_r <= data_b;
      out_pos1_r <= pos_r[1];
    end
  end

  assign sts.cnt_zero = (cnt_r == '0);
  assign sts.out_busy = out_valid_r && !out_ready;

  assign out_valid           = out_valid_r;
  assign out_pattern_first   = out_pat0_r;
  assign out_position_first  = out_pos0_r;
  assign out_pattern_second  = out_pat1_r;
  assign out_position_second = out_pos1_r;

endmodule
